@@ hdl/lea_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lea_pkg
// Shared types, codes and constants of the label extent allocator.
// ----------------------------------------------------------------------------
package lea_pkg;

  localparam int unsigned LABEL_COUNT_DEF = 256;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned LABEL_W         = 8;
  localparam int unsigned AMOUNT_W        = 24;
  localparam int unsigned POS_W           = 32;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 32;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [1:0]           lstate_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_QUERY   = 3'd0;
  localparam kind_t KIND_RESERVE = 3'd1;
  localparam kind_t KIND_NEXT    = 3'd2;
  localparam kind_t KIND_DELETE  = 3'd3;
  localparam kind_t KIND_GIVE    = 3'd4;
  localparam kind_t KIND_RESIZE  = 3'd5;

  localparam status_t STS_OK         = 3'd0;
  localparam status_t STS_IN_USE     = 3'd1;
  localparam status_t STS_RESERVED   = 3'd2;
  localparam status_t STS_DELETED    = 3'd3;
  localparam status_t STS_NO_FREE    = 3'd4;
  localparam status_t STS_NOT_IN_USE = 3'd5;
  localparam status_t STS_EXHAUSTED  = 3'd6;

  localparam lstate_t LS_FREE     = 2'd0;
  localparam lstate_t LS_RESERVED = 2'd1;
  localparam lstate_t LS_USED     = 2'd2;
  localparam lstate_t LS_DELETED  = 2'd3;

  localparam cfg_idx_t CFG_START_POSITION = 1'd0;
  localparam cfg_idx_t CFG_START_LABEL    = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SEARCH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic exec;
    logic srch_step;
    logic srch_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_search;
    logic out_free;
    logic srch_done;
  } dp_stat_t;

endpackage : lea_pkg
`default_nettype wire

@@ hdl/lea_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lea_ctrl
// Sequencer: accepts one beat, steps it through table read and update or
// through the free label walk, and hands it to the result register.
// ----------------------------------------------------------------------------
module lea_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lea_pkg::dp_stat_t stat,
  output lea_pkg::dp_cmd_t       cmd
);
  import lea_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.is_search ? ST_SEARCH : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (stat.srch_done && stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = stat.out_free;
      end
      ST_SEARCH: begin
        cmd.srch_step   = !stat.srch_done;
        cmd.srch_commit = stat.srch_done && stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule : lea_ctrl
`default_nettype wire

@@ hdl/lea_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lea_dp
// Label tables, bump pointer, free label walk and result register.
// ----------------------------------------------------------------------------
module lea_dp #(
  parameter int unsigned LABEL_COUNT = lea_pkg::LABEL_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lea_pkg::kind_t                  in_kind,
  input  wire logic [lea_pkg::LABEL_W-1:0]     in_label,
  input  wire logic [lea_pkg::AMOUNT_W-1:0]    in_amount,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output lea_pkg::status_t                     out_status,
  output logic                                 out_in_use,
  output logic [lea_pkg::LABEL_W-1:0]          out_label_out,
  output logic [lea_pkg::POS_W-1:0]            out_position,
  output logic [lea_pkg::AMOUNT_W-1:0]         out_extent_size,
  input  wire logic                            cfg_valid,
  input  wire lea_pkg::cfg_idx_t               cfg_index,
  input  wire logic [lea_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire lea_pkg::dp_cmd_t                cmd,
  output lea_pkg::dp_stat_t                    stat
);
  import lea_pkg::*;

  localparam int unsigned SPACE   = (LABEL_COUNT < 256) ? LABEL_COUNT : 256;
  localparam int unsigned SW      = $clog2(SPACE);
  localparam logic [8:0]  SPACE_L = 9'(SPACE);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SPACE - 1);

  // label to slot, label mod LABEL_COUNT
  logic [SW-1:0] slot_tab [256];

  always_comb begin
    for (int i = 0; i < 256; i++) begin
      slot_tab[i] = SW'(i % LABEL_COUNT);
    end
  end

  // tables
  logic [1:0]          st_mem  [SPACE];
  logic [POS_W-1:0]    pos_mem [SPACE];
  logic [AMOUNT_W-1:0] ext_mem [SPACE];
  logic [SPACE-1:0]    taken_r;

  logic [1:0]          st_rd_r;
  logic [POS_W-1:0]    pos_rd_r;
  logic [AMOUNT_W-1:0] ext_rd_r;

  // held beat
  kind_t               kind_r;
  logic [LABEL_W-1:0]  label_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic [SW-1:0]       slot_r;

  logic [POS_W-1:0]    next_pos_r;
  logic [LABEL_W-1:0]  last_label_r;
  logic [SW-1:0]       cand_r;
  logic [SW-1:0]       cnt_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic                out_in_use_r;
  logic [LABEL_W-1:0]  out_label_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [AMOUNT_W-1:0] out_ext_r;

  // walk
  logic [8:0]    lab_inc;
  logic [SW-1:0] first_cand;
  logic [SW-1:0] cand_nxt;
  logic          hit;

  assign lab_inc    = {1'b0, last_label_r} + 9'd1;
  assign first_cand = (lab_inc >= SPACE_L) ? '0 : SW'(lab_inc);
  assign cand_nxt   = (cand_r == LAST_SLOT) ? '0 : cand_r + 1'b1;
  assign hit        = (cand_r != '0) && !taken_r[cand_r];

  assign stat.is_search = (in_kind == KIND_NEXT);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.srch_done = hit || (cnt_r == LAST_SLOT);

  // update of a named label
  lstate_t             cur_st;
  lstate_t             new_st;
  lstate_t             fin_st;
  status_t             res_status;
  logic                wr_st;
  logic                wr_ext;
  logic                room;
  logic [POS_W:0]      sum;
  logic                shown;

  assign cur_st = taken_r[slot_r] ? st_rd_r : LS_FREE;
  assign sum    = {1'b0, next_pos_r} + {{(POS_W + 1 - AMOUNT_W){1'b0}}, amount_r};
  assign room   = !sum[POS_W];

  always_comb begin
    res_status = STS_OK;
    new_st     = cur_st;
    wr_st      = 1'b0;
    wr_ext     = 1'b0;
    case (kind_r)
      KIND_RESERVE: begin
        if (cur_st == LS_USED) begin
          res_status = STS_IN_USE;
        end else if (cur_st == LS_RESERVED) begin
          res_status = STS_RESERVED;
        end else if (cur_st == LS_DELETED) begin
          res_status = STS_DELETED;
        end else begin
          new_st = LS_RESERVED;
          wr_st  = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (cur_st == LS_USED) begin
          new_st = LS_DELETED;
          wr_st  = 1'b1;
        end else begin
          res_status = STS_NOT_IN_USE;
        end
      end
      KIND_GIVE: begin
        if (cur_st == LS_DELETED) begin
          res_status = STS_DELETED;
        end else if (cur_st == LS_USED) begin
          res_status = STS_IN_USE;
        end else if (!room) begin
          res_status = STS_EXHAUSTED;
        end else begin
          new_st = LS_USED;
          wr_st  = 1'b1;
          wr_ext = 1'b1;
        end
      end
      KIND_RESIZE: begin
        if (cur_st == LS_DELETED) begin
          res_status = STS_DELETED;
        end else if (cur_st != LS_USED) begin
          res_status = STS_NOT_IN_USE;
        end else if (!room) begin
          res_status = STS_EXHAUSTED;
        end else begin
          wr_ext = 1'b1;
        end
      end
      default: begin
        res_status = STS_OK;
      end
    endcase
  end

  assign fin_st = new_st;
  assign shown  = (fin_st == LS_USED) || (fin_st == LS_DELETED);

  // table writes
  logic          st_we;
  logic [SW-1:0] st_waddr;
  lstate_t       st_wdata;
  logic          ext_we;

  assign st_we    = (cmd.exec && wr_st) || (cmd.srch_commit && hit);
  assign st_waddr = cmd.srch_commit ? cand_r : slot_r;
  assign st_wdata = cmd.srch_commit ? LS_RESERVED : new_st;
  assign ext_we   = cmd.exec && wr_ext;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (ext_we) begin
      pos_mem[slot_r] <= next_pos_r;
      ext_mem[slot_r] <= amount_r;
    end
    if (cmd.rd_en) begin
      st_rd_r  <= st_mem[slot_r];
      pos_rd_r <= pos_mem[slot_r];
      ext_rd_r <= ext_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
    end else if (st_we) begin
      taken_r[st_waddr] <= 1'b1;
    end
  end

  // beat capture and walk counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      label_r  <= in_label;
      amount_r <= in_amount;
      slot_r   <= slot_tab[in_label];
      cand_r   <= first_cand;
      cnt_r    <= '0;
    end else if (cmd.srch_step) begin
      cand_r <= cand_nxt;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // pointer and last label
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pos_r   <= '0;
      last_label_r <= '0;
    end else begin
      if (cfg_valid && (cfg_index == CFG_START_POSITION)) begin
        next_pos_r <= cfg_data;
      end else if (ext_we) begin
        next_pos_r <= sum[POS_W-1:0];
      end
      if (cfg_valid && (cfg_index == CFG_START_LABEL)) begin
        last_label_r <= cfg_data[LABEL_W-1:0];
      end else if (cmd.srch_commit && hit) begin
        last_label_r <= LABEL_W'(cand_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec || cmd.srch_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= res_status;
      out_in_use_r <= (fin_st == LS_USED);
      out_label_r  <= label_r;
      out_pos_r    <= shown ? (wr_ext ? next_pos_r : pos_rd_r) : '0;
      out_ext_r    <= shown ? (wr_ext ? amount_r : ext_rd_r) : '0;
    end else if (cmd.srch_commit) begin
      out_status_r <= hit ? STS_OK : STS_NO_FREE;
      out_in_use_r <= 1'b0;
      out_label_r  <= hit ? LABEL_W'(cand_r) : '0;
      out_pos_r    <= '0;
      out_ext_r    <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_in_use      = out_in_use_r;
  assign out_label_out   = out_label_r;
  assign out_position    = out_pos_r;
  assign out_extent_size = out_ext_r;

endmodule : lea_dp
`default_nettype wire

@@ hdl/label_extent_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// label_extent_allocator
// sequence: a beat's table entry is read, then, once the result register is
//   free, updated and its result written; next label walks up to
//   min(LABEL_COUNT, 256) labels. A new beat is taken once the last result is
//   registered. The free label walk checks one table entry per cycle.
// reset: all labels free, pointer and last label zero, result channel empty
// ----------------------------------------------------------------------------
module label_extent_allocator #(
  parameter int unsigned LABEL_COUNT = lea_pkg::LABEL_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lea_pkg::kind_t                  in_kind,
  input  wire logic [lea_pkg::LABEL_W-1:0]     in_label,
  input  wire logic [lea_pkg::AMOUNT_W-1:0]    in_amount,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lea_pkg::status_t                     out_status,
  output logic                                 out_in_use,
  output logic [lea_pkg::LABEL_W-1:0]          out_label_out,
  output logic [lea_pkg::POS_W-1:0]            out_position,
  output logic [lea_pkg::AMOUNT_W-1:0]         out_extent_size,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire lea_pkg::cfg_idx_t               cfg_index,
  input  wire logic [lea_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lea_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lea_dp #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_label        (in_label),
    .in_amount       (in_amount),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_in_use      (out_in_use),
    .out_label_out   (out_label_out),
    .out_position    (out_position),
    .out_extent_size (out_extent_size),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule : label_extent_allocator
`default_nettype wire
